// ===== rtl/core/key_table_insert_search_assert.svh =====
// Assertion macros shared by the key table checker.
`ifndef KEY_TABLE_INSERT_SEARCH_ASSERT_SVH
`define KEY_TABLE_INSERT_SEARCH_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("key table check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define KTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("key table check failed");

`endif

// ===== rtl/core/kts_pkg.sv =====
// Package with widths, codes and types of the key table.
`default_nettype none

package kts_pkg;

    localparam int KEY_W      = 31;
    localparam int POS_W      = 10;
    localparam int CMP_W      = 11;
    localparam int CAP_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_MISS = 2'd1;
    localparam t_status ST_ERR  = 2'd2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    localparam logic [1:0] METH_BIN  = 2'd0;
    localparam logic [1:0] METH_LIN  = 2'd1;
    localparam logic [1:0] METH_SWAP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SORTED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP    = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

endpackage

`default_nettype wire

// ===== rtl/core/kts_ram.sv =====
// Simple dual-port key memory with one write port and a registered read port.
`default_nettype none

module kts_ram
    import kts_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [KEY_W-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [KEY_W-1:0]         o_rdata
);

    logic [KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/key_table_insert_search.sv =====
// Top level of the key table: insert and search sequencer around the key memory.
// An unsorted insert, an error or a search of an empty table goes straight to the result;
// a sorted insert shifts larger keys up one slot at a time and a linear search reads one
// entry per cycle; a binary search reads and then compares each probe. One item is in work
// at a time; the next is taken in the cycle after the result is loaded into the output.
// Reset clears the entry count and valid flag and resets state and config; memory is kept.
`default_nettype none

module key_table_insert_search
    import kts_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_kind,
    input  wire logic signed [31:0]    i_key,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [1:0]                 o_status,
    output logic [POS_W-1:0]           o_position,
    output logic [CMP_W-1:0]           o_compare_count
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_LIN   = 3'd3;
    localparam logic [2:0] S_SWAP  = 3'd4;
    localparam logic [2:0] S_BRD   = 3'd5;
    localparam logic [2:0] S_BCMP  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_sorted, n_sorted;
    logic [1:0]       r_method, n_method;
    logic [CAP_W-1:0] r_cap, n_cap;
    logic             r_out_valid, n_out_valid;

    logic [KEY_W-1:0] r_key, n_key;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [CW-1:0]    r_mid, n_mid;
    logic [CW-1:0]    r_n, n_n;
    logic [KEY_W-1:0] r_prev, n_prev;
    t_status          r_res_status, n_res_status;
    logic [CW-1:0]    r_res_pos, n_res_pos;
    logic [CW-1:0]    r_res_cmp, n_res_cmp;
    t_status          r_out_status, n_out_status;
    logic [POS_W-1:0] r_out_pos, n_out_pos;
    logic [CMP_W-1:0] r_out_cmp, n_out_cmp;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [KEY_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [KEY_W-1:0] mem_rdata;

    logic             table_full;
    logic [CW-1:0]    idx_m1;
    logic [CW-1:0]    idx_m2;
    logic [CW-1:0]    idx_p1;
    logic [CW-1:0]    mid_calc;
    logic [CW-1:0]    count_m1;

    kts_ram #(
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_position      = r_out_pos;
    assign o_compare_count = r_out_cmp;

    assign table_full = (CMPW'(r_count) >= CMPW'(r_cap)) || (r_count == CW'(TABLE_DEPTH));
    assign idx_m1     = r_idx - CW'(1);
    assign idx_m2     = r_idx - CW'(2);
    assign idx_p1     = r_idx + CW'(1);
    assign count_m1   = r_count - CW'(1);
    assign mid_calc   = r_lo + ((r_hi - r_lo - CW'(1)) >> 1);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_sorted     = r_sorted;
        n_method     = r_method;
        n_cap        = r_cap;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_key        = r_key;
        n_idx        = r_idx;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_n          = r_n;
        n_prev       = r_prev;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        n_res_cmp    = r_res_cmp;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_cmp    = r_out_cmp;
        mem_we       = 1'b0;
        mem_waddr    = r_idx[AW-1:0];
        mem_wdata    = r_key;
        mem_raddr    = r_mid[AW-1:0];

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SORTED: n_sorted = i_cfg_data[0];
                CFG_METHOD: n_method = i_cfg_data[1:0];
                CFG_CAP:    n_cap    = i_cfg_data[CAP_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key        = i_key[KEY_W-1:0];
                    n_res_status = ST_OK;
                    n_res_pos    = '0;
                    n_res_cmp    = '0;
                    n_state      = S_DONE;
                    if (i_key[31]) begin
                        n_res_status = ST_ERR;
                    end else if (i_kind == KIND_INSERT) begin
                        if (table_full) begin
                            n_res_status = ST_ERR;
                        end else if (!r_sorted || r_count == '0) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_count[AW-1:0];
                            mem_wdata = i_key[KEY_W-1:0];
                            n_count   = r_count + CW'(1);
                        end else begin
                            mem_raddr = count_m1[AW-1:0];
                            n_idx     = r_count;
                            n_state   = S_SHIFT;
                        end
                    end else begin
                        case (r_method)
                            METH_BIN: begin
                                if (r_count == '0) begin
                                    n_res_status = ST_MISS;
                                end else begin
                                    n_lo    = '0;
                                    n_hi    = r_count;
                                    n_n     = '0;
                                    n_state = S_BRD;
                                end
                            end
                            METH_LIN, METH_SWAP: begin
                                if (r_count == '0) begin
                                    n_res_status = ST_MISS;
                                end else begin
                                    mem_raddr = '0;
                                    n_idx     = '0;
                                    n_state   = S_LIN;
                                end
                            end
                            default: n_res_status = ST_ERR;
                        endcase
                    end
                end
            end
            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                if (mem_rdata > r_key) begin
                    mem_wdata = mem_rdata;
                    n_idx     = idx_m1;
                    if (idx_m1 == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        mem_raddr = idx_m2[AW-1:0];
                    end
                end else begin
                    mem_wdata = r_key;
                    n_count   = r_count + CW'(1);
                    n_state   = S_DONE;
                end
            end
            S_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = r_key;
                n_count   = r_count + CW'(1);
                n_state   = S_DONE;
            end
            S_LIN: begin
                n_prev = mem_rdata;
                if (mem_rdata == r_key) begin
                    n_res_status = ST_OK;
                    n_res_pos    = r_idx;
                    n_res_cmp    = idx_p1;
                    if (r_method == METH_SWAP && r_idx != '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_idx[AW-1:0];
                        mem_wdata = r_prev;
                        n_state   = S_SWAP;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (idx_p1 == r_count) begin
                    n_res_status = ST_MISS;
                    n_res_cmp    = r_count;
                    n_state      = S_DONE;
                end else begin
                    mem_raddr = idx_p1[AW-1:0];
                    n_idx     = idx_p1;
                end
            end
            S_SWAP: begin
                mem_we    = 1'b1;
                mem_waddr = idx_m1[AW-1:0];
                mem_wdata = r_key;
                n_state   = S_DONE;
            end
            S_BRD: begin
                mem_raddr = mid_calc[AW-1:0];
                n_mid     = mid_calc;
                n_n       = r_n + CW'(1);
                n_state   = S_BCMP;
            end
            S_BCMP: begin
                if (mem_rdata == r_key) begin
                    n_res_status = ST_OK;
                    n_res_pos    = r_mid;
                    n_res_cmp    = r_n;
                    n_state      = S_DONE;
                end else begin
                    if (mem_rdata < r_key) begin
                        n_lo = r_mid + CW'(1);
                    end else begin
                        n_hi = r_mid;
                    end
                    if (n_lo < n_hi) begin
                        n_state = S_BRD;
                    end else begin
                        n_res_status = ST_MISS;
                        n_res_cmp    = r_n;
                        n_state      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_pos    = POS_W'(r_res_pos);
                    n_out_cmp    = CMP_W'(r_res_cmp);
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sorted    <= 1'b0;
            r_method    <= METH_BIN;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sorted    <= n_sorted;
            r_method    <= n_method;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_n          <= n_n;
        r_prev       <= n_prev;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_res_cmp    <= n_res_cmp;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_cmp    <= n_out_cmp;
    end

endmodule

`default_nettype wire

// ===== rtl/core/kts_check.sv =====
// Port-level checker for the key table and its bind to the top level.
`default_nettype none

`include "key_table_insert_search_assert.svh"

module kts_check
    import kts_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_ready,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [1:0]            o_status,
    input wire logic [POS_W-1:0]      o_position,
    input wire logic [CMP_W-1:0]      o_compare_count
);

    // A result that is not taken stays offered.
    `KTS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // Only one item is in work at a time.
    `KTS_ASSERT_NEXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready)

    // Misses and errors carry no position.
    `KTS_ASSERT_SAME(a_pos_zero, o_out_valid && o_status != ST_OK, o_position == '0)

    // Errors carry no comparisons.
    `KTS_ASSERT_SAME(a_err_cmp, o_out_valid && o_status == ST_ERR, o_compare_count == '0)

endmodule

bind key_table_insert_search kts_check u_kts_check (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the key table: a directed script, then random insert and search phases.
`timescale 1ns / 100ps

module tb_top;
    import kts_pkg::*;

    localparam int TBL_DEPTH = 1024;
    localparam logic [1:0] METH_UNUSED = 2'd3;
    localparam logic [CAP_W-1:0] CAP_FIELD_MAX = '1;
    localparam logic ROW_ITEM = 1'b0;
    localparam logic ROW_CFG = 1'b1;
    localparam logic PRED = 1'b0;
    localparam logic PINNED = 1'b1;

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] position;
        logic [CMP_W-1:0] compares;
    } lookup_result_t;

    // A pinned row expects the given status with zero position and zero compare count.
    typedef struct packed {
        logic             is_cfg;
        logic             kind;
        logic [31:0]      key;
        logic             pinned;
        t_status          status;
        logic             sorted;
        logic [1:0]       method;
        logic [CAP_W-1:0] cap;
    } script_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic                   i_kind = 1'b0;
    logic signed [31:0]     i_key = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [1:0]             o_status;
    logic [POS_W-1:0]       o_position;
    logic [CMP_W-1:0]       o_compare_count;

    logic [KEY_W-1:0]       key_mem [TBL_DEPTH];
    int unsigned            key_count = 0;
    logic                   sorted_cfg = 1'b0;
    logic [1:0]             method_cfg = METH_BIN;
    logic [CAP_W-1:0]       cap_cfg = CAP_RESET;

    lookup_result_t         expected_results [$];
    lookup_result_t         want;
    int unsigned            mismatch_count = 0;
    int unsigned            results_seen = 0;
    int unsigned            stall_left = 0;
    logic                   rx_steady = 1'b0;
    logic                   tx_steady = 1'b0;

    script_row_t script_rows [25] = '{
        '{ROW_ITEM, KIND_SEARCH, 32'd5,         PINNED, ST_MISS, 1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_INSERT, 32'h8000_0000, PINNED, ST_ERR,  1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_SEARCH, 32'hFFFF_FFFF, PINNED, ST_ERR,  1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_INSERT, 32'd0,         PINNED, ST_OK,   1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_INSERT, 32'd1000,      PINNED, ST_OK,   1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_INSERT, 32'h7FFF_FFFF, PINNED, ST_OK,   1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_SEARCH, 32'h7FFF_FFFF, PRED,   ST_OK,   1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_SEARCH, 32'd0,         PRED,   ST_OK,   1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_SEARCH, 32'd999,       PRED,   ST_OK,   1'b0, METH_BIN, 11'd0},
        '{ROW_CFG,  KIND_INSERT, 32'd0,         PRED,   ST_OK,   1'b0, METH_LIN, CAP_RESET},
        '{ROW_ITEM, KIND_SEARCH, 32'd1000,      PRED,   ST_OK,   1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_SEARCH, 32'd4,         PRED,   ST_OK,   1'b0, METH_BIN, 11'd0},
        '{ROW_CFG,  KIND_INSERT, 32'd0,         PRED,   ST_OK,   1'b0, METH_SWAP, CAP_RESET},
        '{ROW_ITEM, KIND_SEARCH, 32'd1000,      PRED,   ST_OK,   1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_SEARCH, 32'd0,         PRED,   ST_OK,   1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_SEARCH, 32'd0,         PRED,   ST_OK,   1'b0, METH_BIN, 11'd0},
        '{ROW_CFG,  KIND_INSERT, 32'd0,         PRED,   ST_OK,   1'b1, METH_UNUSED, 11'd0},
        '{ROW_ITEM, KIND_SEARCH, 32'd0,         PINNED, ST_ERR,  1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_INSERT, 32'd5,         PINNED, ST_ERR,  1'b0, METH_BIN, 11'd0},
        '{ROW_CFG,  KIND_INSERT, 32'd0,         PRED,   ST_OK,   1'b1, METH_BIN, CAP_FIELD_MAX},
        '{ROW_ITEM, KIND_INSERT, 32'd1000,      PINNED, ST_OK,   1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_INSERT, 32'd7,         PINNED, ST_OK,   1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_INSERT, 32'h7FFF_FFFF, PINNED, ST_OK,   1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_SEARCH, 32'd1000,      PRED,   ST_OK,   1'b0, METH_BIN, 11'd0},
        '{ROW_ITEM, KIND_SEARCH, 32'd7,         PRED,   ST_OK,   1'b0, METH_BIN, 11'd0}
    };

    key_table_insert_search #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_kind(i_kind),
        .i_key(i_key),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_position(o_position),
        .o_compare_count(o_compare_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic lookup_result_t predict_key_table(input logic kind, input logic [31:0] key);
        lookup_result_t   res;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] tmp;
        int unsigned      lim;
        int unsigned      j;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        int unsigned      n;
        res = '0;
        k = key[KEY_W-1:0];
        if (key[31]) begin
            res.status = ST_ERR;
            return res;
        end
        if (kind == KIND_INSERT) begin
            lim = (cap_cfg < TBL_DEPTH) ? cap_cfg : TBL_DEPTH;
            if (key_count >= lim) begin
                res.status = ST_ERR;
            end else if (!sorted_cfg) begin
                key_mem[key_count] = k;
                key_count++;
            end else begin
                j = key_count;
                while (j > 0 && key_mem[j-1] > k) begin
                    key_mem[j] = key_mem[j-1];
                    j--;
                end
                key_mem[j] = k;
                key_count++;
            end
            return res;
        end
        case (method_cfg)
            METH_BIN: begin
                lo = 0;
                hi = key_count;
                n = 0;
                res.status = ST_MISS;
                while (lo < hi && res.status == ST_MISS) begin
                    mid = lo + (hi - lo - 1) / 2;
                    n++;
                    if (key_mem[mid] == k) begin
                        res.status = ST_OK;
                        res.position = POS_W'(mid);
                    end else if (key_mem[mid] < k) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid;
                    end
                end
                res.compares = CMP_W'(n);
            end
            METH_LIN, METH_SWAP: begin
                res.status = ST_MISS;
                res.compares = CMP_W'(key_count);
                for (j = 0; j < key_count && res.status == ST_MISS; j++) begin
                    if (key_mem[j] == k) begin
                        res.status = ST_OK;
                        res.position = POS_W'(j);
                        res.compares = CMP_W'(j + 1);
                        if (method_cfg == METH_SWAP && j > 0) begin
                            tmp = key_mem[j];
                            key_mem[j] = key_mem[j-1];
                            key_mem[j-1] = tmp;
                        end
                    end
                end
            end
            default: begin
                res.status = ST_ERR;
            end
        endcase
        return res;
    endfunction

    function automatic int unsigned pick_gap(input logic steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Searches often pick a stored key so that hits land across the table.
    function automatic logic [31:0] pick_key(input logic kind);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 7) begin
            return $urandom() | 32'h8000_0000;
        end
        if (r < 10) begin
            return 32'h7FFF_FFFF;
        end
        if (r < 13) begin
            return 32'd0;
        end
        if (kind == KIND_SEARCH && key_count != 0 && r < 60) begin
            return {1'b0, key_mem[$urandom_range(0, key_count - 1)]};
        end
        if (r < 75) begin
            return $urandom_range(0, 300);
        end
        return $urandom() & 32'h7FFF_FFFF;
    endfunction

    task automatic idle_gap();
        int unsigned g;
        g = pick_gap(tx_steady);
        if (g != 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic send_item(input logic kind, input logic [31:0] key, input logic pinned,
                             input t_status pinned_status);
        lookup_result_t res;
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_key <= key;
        do @(posedge i_clk); while (!o_in_ready);
        res = predict_key_table(kind, key);
        if (pinned) begin
            res = '0;
            res.status = pinned_status;
        end
        expected_results.push_back(res);
        @(negedge i_clk);
    endtask

    task automatic program_table(input logic sorted, input logic [1:0] method,
                                 input logic [CAP_W-1:0] cap);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_SORTED;
        i_cfg_data <= CFG_DATA_W'(sorted);
        @(negedge i_clk);
        i_cfg_index <= CFG_METHOD;
        i_cfg_data <= CFG_DATA_W'(method);
        @(negedge i_clk);
        i_cfg_index <= CFG_CAP;
        i_cfg_data <= cap;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sorted_cfg = sorted;
        method_cfg = method;
        cap_cfg = cap;
    endtask

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            stall_left <= pick_gap(rx_steady);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("result %0d with no item pending: status %0d position %0d compares %0d",
                             results_seen, o_status, o_position, o_compare_count);
                end
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status || o_position !== want.position ||
                    o_compare_count !== want.compares) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result %0d: expected status %0d position %0d compares %0d, got %0d %0d %0d",
                                 results_seen, want.status, want.position, want.compares,
                                 o_status, o_position, o_compare_count);
                    end
                end
            end
        end
    end

    initial begin
        int unsigned  phase;
        int unsigned  n;
        int unsigned  n_items;
        int unsigned  r;
        logic         sorted;
        logic [1:0]   method;
        logic [CAP_W-1:0] cap;
        logic         kind;
        logic [31:0]  key;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script_rows[i]) begin
            if (script_rows[i].is_cfg) begin
                program_table(script_rows[i].sorted, script_rows[i].method, script_rows[i].cap);
            end else begin
                idle_gap();
                send_item(script_rows[i].kind, script_rows[i].key, script_rows[i].pinned,
                          script_rows[i].status);
            end
        end

        // Early phases keep the table in order so binary search hits stay meaningful.
        for (phase = 0; phase < 16; phase++) begin
            if (phase < 5) begin
                sorted = 1'b1;
                method = ($urandom_range(0, 1) == 0) ? METH_BIN : METH_LIN;
            end else begin
                sorted = $urandom_range(0, 1);
                r = $urandom_range(0, 9);
                method = (r == 0) ? METH_UNUSED : (r < 4) ? METH_BIN :
                         (r < 7) ? METH_LIN : METH_SWAP;
            end
            r = $urandom_range(0, 99);
            if (r < 12) begin
                cap = '0;
            end else if (r < 20) begin
                cap = CAP_RESET;
            end else if (r < 26) begin
                cap = CAP_FIELD_MAX;
            end else begin
                cap = CAP_W'(key_count + $urandom_range(0, 24));
            end
            rx_steady = ($urandom_range(0, 3) == 0);
            tx_steady = ($urandom_range(0, 3) == 0);
            program_table(sorted, method, cap);
            n_items = $urandom_range(28, 44);
            for (n = 0; n < n_items; n++) begin
                kind = ($urandom_range(0, 99) < 45) ? KIND_INSERT : KIND_SEARCH;
                key = pick_key(kind);
                idle_gap();
                send_item(kind, key, PRED, ST_OK);
            end
        end

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
